FILE: rtl/qtm_pkg.sv
package qtm_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 16;
    localparam int POS_W   = 32;
    localparam int OUT_W   = 32;

    // raw quaternion product, Q2.28
    localparam int PROD_W  = 2 * QUAT_W;
    // doubled sum of two products or one minus it, Q.28 with headroom
    localparam int ENTRY_W = PROD_W + 3;
    // entry times scale, Q.36
    localparam int MUL_W   = ENTRY_W + SCALE_W;

    localparam int FRAC_IN   = 28;
    localparam int DROP_BITS = 20;
    localparam int ENTRY_CNT = 9;
    localparam int AXIS_CNT  = 3;

    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [SCALE_W-1:0] t_scale;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [OUT_W-1:0]   t_out;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [MUL_W-1:0]   t_mul;

    localparam t_entry ONE_Q28  = t_entry'(1) <<< FRAC_IN;
    localparam t_mul   HALF_LSB = t_mul'(1) <<< (DROP_BITS - 1);

endpackage

FILE: rtl/qtm_scale_round.sv
module qtm_scale_round (
    input  logic            i_clk,
    input  qtm_pkg::t_entry i_entry,
    input  qtm_pkg::t_scale i_scale,
    output qtm_pkg::t_out   o_result
);

    localparam int HI_W = qtm_pkg::MUL_W - qtm_pkg::OUT_W + 1;

    qtm_pkg::t_mul r_prod;
    qtm_pkg::t_mul n_prod;
    qtm_pkg::t_mul shifted;
    qtm_pkg::t_out r_result;
    qtm_pkg::t_out n_result;
    logic [HI_W-1:0] hi_bits;

    always_comb begin
        n_prod = qtm_pkg::t_mul'(i_entry) * qtm_pkg::t_mul'(i_scale) + qtm_pkg::HALF_LSB;
    end

    // floor by arithmetic shift, then clamp if the top bits are not all sign
    always_comb begin
        shifted = r_prod >>> qtm_pkg::DROP_BITS;
        hi_bits = shifted[qtm_pkg::MUL_W-1:qtm_pkg::OUT_W-1];
        if ((hi_bits == '0) || (hi_bits == '1)) begin
            n_result = shifted[qtm_pkg::OUT_W-1:0];
        end else if (shifted[qtm_pkg::MUL_W-1]) begin
            n_result = {1'b1, {(qtm_pkg::OUT_W-1){1'b0}}};
        end else begin
            n_result = {1'b0, {(qtm_pkg::OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

FILE: rtl/quaternion_trs_to_matrix_unit.sv
// Quaternion/scale/translation to 3x4 affine model matrix, column-major.
// Request channel: drive the quaternion (Q1.14), scale (Q8.8) and position
// (Q16.16) ports and raise start; a request is taken at each rising edge
// where start is high and busy is low. busy is low whenever reset is
// released, so a new request may enter on every cycle.
// Result channel: o_valid pulses for one cycle with the nine rotation-scale
// entries and the translation column on the o_ ports; there is no stall.
// Throughput is one matrix per cycle. The four stages are: the nine
// 16x16 quaternion products, the doubled sums that form the entries, the
// 35x16 scale multiply with rounding offset, and the shift and clamp.
// Reset (synchronous, active low) clears the stage valid bits, so no result
// strobe appears for requests in flight; busy is high while reset is held.
module quaternion_trs_to_matrix_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [15:0]    i_quat_x,
    input  logic signed [15:0]    i_quat_y,
    input  logic signed [15:0]    i_quat_z,
    input  logic signed [15:0]    i_quat_w,
    input  logic signed [15:0]    i_scale_x,
    input  logic signed [15:0]    i_scale_y,
    input  logic signed [15:0]    i_scale_z,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    output logic                  o_valid,
    output logic signed [31:0]    o_col0_row0,
    output logic signed [31:0]    o_col0_row1,
    output logic signed [31:0]    o_col0_row2,
    output logic signed [31:0]    o_col1_row0,
    output logic signed [31:0]    o_col1_row1,
    output logic signed [31:0]    o_col1_row2,
    output logic signed [31:0]    o_col2_row0,
    output logic signed [31:0]    o_col2_row1,
    output logic signed [31:0]    o_col2_row2,
    output logic signed [31:0]    o_trans_x,
    output logic signed [31:0]    o_trans_y,
    output logic signed [31:0]    o_trans_z
);

    localparam int DEPTH = 4;
    localparam int AX    = qtm_pkg::AXIS_CNT;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic             accept;

    // stage 1: products
    qtm_pkg::t_prod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qtm_pkg::t_scale r_s1_scale [AX];
    // stage 2: entries
    qtm_pkg::t_entry r_s2_entry [qtm_pkg::ENTRY_CNT];
    qtm_pkg::t_entry n_s2_entry [qtm_pkg::ENTRY_CNT];
    qtm_pkg::t_scale r_s2_scale [AX];
    // translation rides along all four stages
    qtm_pkg::t_pos r_pos [DEPTH][AX];
    qtm_pkg::t_out result [qtm_pkg::ENTRY_CNT];

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_comb begin
        n_vld = {r_vld[DEPTH-2:0], accept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= qtm_pkg::t_prod'(i_quat_x) * qtm_pkg::t_prod'(i_quat_x);
        r_yy <= qtm_pkg::t_prod'(i_quat_y) * qtm_pkg::t_prod'(i_quat_y);
        r_zz <= qtm_pkg::t_prod'(i_quat_z) * qtm_pkg::t_prod'(i_quat_z);
        r_xy <= qtm_pkg::t_prod'(i_quat_x) * qtm_pkg::t_prod'(i_quat_y);
        r_xz <= qtm_pkg::t_prod'(i_quat_x) * qtm_pkg::t_prod'(i_quat_z);
        r_yz <= qtm_pkg::t_prod'(i_quat_y) * qtm_pkg::t_prod'(i_quat_z);
        r_wx <= qtm_pkg::t_prod'(i_quat_w) * qtm_pkg::t_prod'(i_quat_x);
        r_wy <= qtm_pkg::t_prod'(i_quat_w) * qtm_pkg::t_prod'(i_quat_y);
        r_wz <= qtm_pkg::t_prod'(i_quat_w) * qtm_pkg::t_prod'(i_quat_z);
        r_s1_scale[0] <= i_scale_x;
        r_s1_scale[1] <= i_scale_y;
        r_s1_scale[2] <= i_scale_z;
    end

    always_comb begin
        n_s2_entry[0] = qtm_pkg::ONE_Q28
            - ((qtm_pkg::t_entry'(r_yy) + qtm_pkg::t_entry'(r_zz)) <<< 1);
        n_s2_entry[1] = (qtm_pkg::t_entry'(r_xy) + qtm_pkg::t_entry'(r_wz)) <<< 1;
        n_s2_entry[2] = (qtm_pkg::t_entry'(r_xz) - qtm_pkg::t_entry'(r_wy)) <<< 1;
        n_s2_entry[3] = (qtm_pkg::t_entry'(r_xy) - qtm_pkg::t_entry'(r_wz)) <<< 1;
        n_s2_entry[4] = qtm_pkg::ONE_Q28
            - ((qtm_pkg::t_entry'(r_xx) + qtm_pkg::t_entry'(r_zz)) <<< 1);
        n_s2_entry[5] = (qtm_pkg::t_entry'(r_yz) + qtm_pkg::t_entry'(r_wx)) <<< 1;
        n_s2_entry[6] = (qtm_pkg::t_entry'(r_xz) + qtm_pkg::t_entry'(r_wy)) <<< 1;
        n_s2_entry[7] = (qtm_pkg::t_entry'(r_yz) - qtm_pkg::t_entry'(r_wx)) <<< 1;
        n_s2_entry[8] = qtm_pkg::ONE_Q28
            - ((qtm_pkg::t_entry'(r_xx) + qtm_pkg::t_entry'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_s2_entry <= n_s2_entry;
        r_s2_scale <= r_s1_scale;
        r_pos[0][0] <= i_pos_x;
        r_pos[0][1] <= i_pos_y;
        r_pos[0][2] <= i_pos_z;
        for (int s = 1; s < DEPTH; s++) begin
            r_pos[s] <= r_pos[s-1];
        end
    end

    for (genvar k = 0; k < qtm_pkg::ENTRY_CNT; k++) begin : g_entry
        qtm_scale_round u_scale_round (
            .i_clk    (i_clk),
            .i_entry  (r_s2_entry[k]),
            .i_scale  (r_s2_scale[k / AX]),
            .o_result (result[k])
        );
    end

    assign o_valid     = r_vld[DEPTH-1];
    assign o_col0_row0 = result[0];
    assign o_col0_row1 = result[1];
    assign o_col0_row2 = result[2];
    assign o_col1_row0 = result[3];
    assign o_col1_row1 = result[4];
    assign o_col1_row2 = result[5];
    assign o_col2_row0 = result[6];
    assign o_col2_row1 = result[7];
    assign o_col2_row2 = result[8];
    assign o_trans_x   = r_pos[DEPTH-1][0];
    assign o_trans_y   = r_pos[DEPTH-1][1];
    assign o_trans_z   = r_pos[DEPTH-1][2];

endmodule

FILE: rtl/qtm_checker.sv
module qtm_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic signed [15:0]    i_quat_x,
    input  logic signed [15:0]    i_quat_y,
    input  logic signed [15:0]    i_quat_z,
    input  logic signed [15:0]    i_quat_w,
    input  logic signed [15:0]    i_scale_x,
    input  logic signed [31:0]    i_pos_x,
    input  logic                  o_valid,
    input  logic signed [31:0]    o_col0_row0,
    input  logic signed [31:0]    o_trans_x
);

    logic quat_zero;
    assign quat_zero = (i_quat_x == '0) && (i_quat_y == '0) && (i_quat_z == '0)
        && (i_quat_w == '0);

    // one strobe per accepted request
    a_strobe_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
            && $past(i_rst_n, 4))
        |-> (o_valid == $past(start && !busy, 4)))
        else $error("result strobe does not match request four cycles back");

    // reset drops requests in flight
    a_reset_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    a_trans_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_trans_x == $past(i_pos_x, 4)))
        else $error("translation x not passed through");

    // zero quaternion leaves the first diagonal at exactly scale x
    a_zero_quat_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(quat_zero, 4))
        |-> (o_col0_row0 == {{8{$past(i_scale_x[15], 4)}}, $past(i_scale_x, 4), 8'h00}))
        else $error("diagonal entry wrong for zero rotation");

endmodule

bind quaternion_trs_to_matrix_unit qtm_checker u_qtm_checker (.*);
